FILE: rtl/iep_pkg.sv
// Package for the ICMP echo ping engine: shared codes, frame constants and
// the structs passed between the front end, the job queue and the serializer.
// No dependencies.
package iep_pkg;

    // Input operations
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_RECV  = 2'd2
    } op_t;

    // Outcome status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TIMEOUT   = 2'd1,
        ST_NO_GW     = 2'd2,
        ST_LINK_DOWN = 2'd3
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PEER_IP  = 2'd0,
        REG_SELF_IP  = 2'd1,
        REG_PEER_MAC = 2'd2,
        REG_SELF_MAC = 2'd3
    } reg_idx_t;

    localparam int CFG_DATA_BITS = 48;
    localparam int QUEUE_DEPTH   = 4;
    localparam int FRAME_SIZE    = 50;

    // Protocol constants
    localparam logic [15:0] DEFAULT_WAIT   = 16'd1000;
    localparam logic [15:0] ECHO_IDENT     = 16'h5153;
    localparam logic [15:0] MIN_ECHO_LEN   = 16'd8;
    localparam logic [15:0] ETHERTYPE_IP4  = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [15:0] IP_DGRAM_LEN   = 16'd36;
    localparam logic [7:0]  IP_TTL         = 8'd64;
    localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
    localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
    localparam logic [31:0] PAYLOAD_TAG    = 32'h514F5321;

    // Constant words of both headers, summed at elaboration
    localparam logic [19:0] IP_CONST_SUM =
        20'({IP_VER_IHL, 8'h00}) + 20'(IP_DGRAM_LEN) + 20'({IP_TTL, IP_PROTO_ICMP});
    localparam logic [19:0] ICMP_CONST_SUM =
        20'({ICMP_ECHO_REQ, 8'h00}) + 20'(ECHO_IDENT)
        + 20'(PAYLOAD_TAG[31:16]) + 20'(PAYLOAD_TAG[15:0]);

    typedef struct packed {
        logic [31:0] peer_ip;
        logic [31:0] self_ip;
        logic [47:0] peer_mac;
        logic [47:0] self_mac;
    } cfg_t;

    typedef struct packed {
        logic [31:0] tx;
        logic [31:0] reply;
        logic [31:0] other;
        logic [31:0] bad;
        logic [31:0] timeout;
    } cnt_snap_t;

    // One unit of work for the serializer: a request frame or an outcome
    typedef struct packed {
        logic        is_frame;
        status_t     status;
        logic [15:0] rtt;
        logic [15:0] seq;
        logic [31:0] tick;
        cnt_snap_t   cnt;
    } job_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_byte;
        logic        last;
        status_t     status;
        logic [15:0] rtt;
        cnt_snap_t   cnt;
    } res_t;

    // Fold a raw sum of 16-bit words and take the ones' complement
    function automatic logic [15:0] csum_finish(input logic [19:0] raw);
        logic [16:0] f1;
        logic [15:0] f2;
        f1 = 17'(raw[15:0]) + 17'(raw[19:16]);
        f2 = f1[15:0] + 16'(f1[16]);
        return ~f2;
    endfunction

endpackage

FILE: rtl/icmp_echo_ping_engine.sv
// Top level of the ICMP echo ping engine: configuration registers, front
// end, job queue and frame serializer. Depends on iep_pkg and all iep_ modules.
//
// The engine takes one item per cycle (tick, start or received header) as
// long as full is low. Items that produce results leave a job in a
// four-entry queue; a serializer drains it at one result transfer per
// cycle while results are popped: a successful start gives 50 frame-byte
// transfers, every outcome one transfer. Every item waits while the queue
// is full, so a burst of starts is paced by the serializer once the queue
// has filled. A job is loaded into the serializer's job register and its
// result is then registered in the output register. Configuration
// writes take effect at the next clock and belong to idle periods.
module icmp_echo_ping_engine import iep_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     push,
    output logic                     full,
    input  logic [1:0]               operation,
    input  logic [15:0]              timeout,
    input  logic                     link_ready,
    input  logic                     gateway_resolved,
    input  logic [31:0]              src_ip,
    input  logic [15:0]              data_len,
    input  logic [7:0]               icmp_type,
    input  logic [7:0]               icmp_code,
    input  logic [15:0]              echo_ident,
    input  logic [15:0]              echo_seq,
    output logic                     empty,
    input  logic                     pop,
    output logic                     kind,
    output logic [7:0]               frame_byte,
    output logic                     last,
    output logic [1:0]               status,
    output logic [15:0]              rtt_ticks,
    output logic [31:0]              tx_count,
    output logic [31:0]              reply_count,
    output logic [31:0]              other_count,
    output logic [31:0]              bad_reply_count,
    output logic [31:0]              timeout_count
);

    cfg_t cfg_reg;
    logic q_full;
    logic q_push;
    job_t q_wr_job;
    logic q_pop;
    job_t q_rd_job;
    logic q_empty;
    res_t res;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PEER_IP:  cfg_reg.peer_ip  <= cfg_data[31:0];
                REG_SELF_IP:  cfg_reg.self_ip  <= cfg_data[31:0];
                REG_PEER_MAC: cfg_reg.peer_mac <= cfg_data[47:0];
                REG_SELF_MAC: cfg_reg.self_mac <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    assign full = q_full;

    iep_front #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .operation        (operation),
        .timeout          (timeout),
        .link_ready       (link_ready),
        .gateway_resolved (gateway_resolved),
        .src_ip           (src_ip),
        .data_len         (data_len),
        .icmp_type        (icmp_type),
        .icmp_code        (icmp_code),
        .echo_ident       (echo_ident),
        .echo_seq         (echo_seq),
        .peer_ip          (cfg_reg.peer_ip),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_job            (q_wr_job)
    );

    iep_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_job (q_wr_job),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_job (q_rd_job),
        .empty  (q_empty)
    );

    iep_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_job   (q_rd_job),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    // Break the result item out to its ports
    assign kind            = res.kind;
    assign frame_byte      = res.frame_byte;
    assign last            = res.last;
    assign status          = res.status;
    assign rtt_ticks       = res.rtt;
    assign tx_count        = res.cnt.tx;
    assign reply_count     = res.cnt.reply;
    assign other_count     = res.cnt.other;
    assign bad_reply_count = res.cnt.bad;
    assign timeout_count   = res.cnt.timeout;

endmodule

FILE: rtl/iep_queue.sv
// Job queue between the ping front end and the frame serializer.
// Depends on iep_pkg for job_t and the queue depth.
module iep_queue import iep_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic empty
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    job_t                mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign full   = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + CNT_BITS'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - CNT_BITS'(1);
        end
    end

    // Store the incoming job
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

FILE: rtl/iep_front.sv
// Front end of the ping engine: accepts items, keeps time, sequence, wait
// state and counters, and queues frame or outcome jobs. Depends on iep_pkg.
module iep_front import iep_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [1:0]  operation,
    input  logic [15:0] timeout,
    input  logic        link_ready,
    input  logic        gateway_resolved,
    input  logic [31:0] src_ip,
    input  logic [15:0] data_len,
    input  logic [7:0]  icmp_type,
    input  logic [7:0]  icmp_code,
    input  logic [15:0] echo_ident,
    input  logic [15:0] echo_seq,
    input  logic [31:0] peer_ip,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    logic                    accept;
    logic [31:0]             tick_reg, tick_next;
    logic [15:0]             next_seq_reg, next_seq_next;
    logic                    waiting_reg, waiting_next;
    logic [15:0]             awaited_reg, awaited_next;
    logic [31:0]             send_tick_reg, send_tick_next;
    logic [15:0]             limit_reg, limit_next;
    logic [COUNTER_BITS-1:0] sent_reg, sent_next;
    logic [COUNTER_BITS-1:0] reply_reg, reply_next;
    logic [COUNTER_BITS-1:0] other_reg, other_next;
    logic [COUNTER_BITS-1:0] bad_reg, bad_next;
    logic [COUNTER_BITS-1:0] tmo_reg, tmo_next;

    logic [31:0] tick_inc;
    logic [31:0] elapsed;
    logic [31:0] rtt_raw;
    logic        timeout_hit;
    logic        echo_shape;
    logic        echo_match;
    logic        job_valid;

    assign accept      = push && !q_full;
    assign tick_inc    = tick_reg + 32'd1;
    assign elapsed     = tick_inc - send_tick_reg;
    assign timeout_hit = waiting_reg && (elapsed >= 32'(limit_reg));
    assign rtt_raw     = tick_reg - send_tick_reg;
    assign echo_shape  = (data_len >= MIN_ECHO_LEN) && (icmp_type == 8'd0)
                         && (icmp_code == 8'd0);
    assign echo_match  = (echo_ident == ECHO_IDENT) && (echo_seq == awaited_reg)
                         && (src_ip == peer_ip);

    // Classify the item and work out the next state and the job
    always_comb
    begin
        tick_next      = tick_reg;
        next_seq_next  = next_seq_reg;
        waiting_next   = waiting_reg;
        awaited_next   = awaited_reg;
        send_tick_next = send_tick_reg;
        limit_next     = limit_reg;
        sent_next      = sent_reg;
        reply_next     = reply_reg;
        other_next     = other_reg;
        bad_next       = bad_reg;
        tmo_next       = tmo_reg;
        job_valid      = 1'b0;
        q_job          = '0;

        unique case (operation)
            OP_TICK:
            begin
                tick_next = tick_inc;
                if (timeout_hit)
                begin
                    waiting_next = 1'b0;
                    tmo_next     = tmo_reg + COUNTER_BITS'(1);
                    job_valid    = 1'b1;
                    q_job.status = ST_TIMEOUT;
                end
            end
            OP_START:
            begin
                job_valid = 1'b1;
                if (!link_ready)
                    q_job.status = ST_LINK_DOWN;
                else if (!gateway_resolved)
                    q_job.status = ST_NO_GW;
                else
                begin
                    q_job.is_frame = 1'b1;
                    q_job.status   = ST_OK;
                    q_job.seq      = next_seq_reg;
                    q_job.tick     = tick_reg;
                    next_seq_next  = next_seq_reg + 16'd1;
                    awaited_next   = next_seq_reg;
                    send_tick_next = tick_reg;
                    limit_next     = (timeout == 16'd0) ? DEFAULT_WAIT : timeout;
                    waiting_next   = 1'b1;
                    sent_next      = sent_reg + COUNTER_BITS'(1);
                end
            end
            OP_RECV:
            begin
                if (!echo_shape)
                    other_next = other_reg + COUNTER_BITS'(1);
                else
                begin
                    reply_next = reply_reg + COUNTER_BITS'(1);
                    if (waiting_reg)
                    begin
                        if (!echo_match)
                            bad_next = bad_reg + COUNTER_BITS'(1);
                        else
                        begin
                            waiting_next = 1'b0;
                            job_valid    = 1'b1;
                            q_job.status = ST_OK;
                            q_job.rtt    = (rtt_raw[31:16] != 16'd0) ? 16'hFFFF
                                                                     : rtt_raw[15:0];
                        end
                    end
                end
            end
            default: ;
        endcase

        // Outcomes and frames show the counters after this item
        q_job.cnt.tx      = 32'(sent_next);
        q_job.cnt.reply   = 32'(reply_next);
        q_job.cnt.other   = 32'(other_next);
        q_job.cnt.bad     = 32'(bad_next);
        q_job.cnt.timeout = 32'(tmo_next);
    end

    assign q_push = accept && job_valid;

    // Hold engine state, update on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            next_seq_reg  <= 16'd1;
            waiting_reg   <= 1'b0;
            awaited_reg   <= '0;
            send_tick_reg <= '0;
            limit_reg     <= '0;
            sent_reg      <= '0;
            reply_reg     <= '0;
            other_reg     <= '0;
            bad_reg       <= '0;
            tmo_reg       <= '0;
        end
        else if (accept)
        begin
            tick_reg      <= tick_next;
            next_seq_reg  <= next_seq_next;
            waiting_reg   <= waiting_next;
            awaited_reg   <= awaited_next;
            send_tick_reg <= send_tick_next;
            limit_reg     <= limit_next;
            sent_reg      <= sent_next;
            reply_reg     <= reply_next;
            other_reg     <= other_next;
            bad_reg       <= bad_next;
            tmo_reg       <= tmo_next;
        end
    end

endmodule

FILE: rtl/iep_back.sv
// Serializer of the ping engine: turns queued jobs into result transfers,
// one echo-request frame byte or one outcome per cycle while results are popped. Depends on iep_pkg.
module iep_back import iep_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_empty,
    input  job_t q_job,
    output logic q_pop,
    input  logic pop,
    output logic empty,
    output res_t res
);

    localparam int IDX_BITS = $clog2(FRAME_SIZE);

    logic                busy_reg;
    logic                ovalid_reg;
    logic [IDX_BITS-1:0] idx_reg;
    job_t                job_reg;
    logic [19:0]         ip_sum_reg;
    logic [19:0]         icmp_sum_reg;
    res_t                res_reg;

    logic                produce;
    logic                finish;
    logic                load;
    logic [7:0]          cur_byte;
    logic [15:0]         ip_csum;
    logic [15:0]         icmp_csum;
    logic [19:0]         ip_sum_new;
    logic [19:0]         icmp_sum_new;
    res_t                item;

    // Big-endian byte pos of a 48-bit or 32-bit value
    function automatic logic [7:0] be_byte48(input logic [47:0] v,
                                              input logic [IDX_BITS-1:0] pos);
        logic [5:0] sh;
        sh = 6'(6'd40 - {pos[2:0], 3'b000});
        return 8'(v >> sh);
    endfunction

    function automatic logic [7:0] be_byte32(input logic [31:0] v,
                                              input logic [IDX_BITS-1:0] pos);
        logic [4:0] sh;
        sh = 5'(5'd24 - {pos[1:0], 3'b000});
        return 8'(v >> sh);
    endfunction

    assign produce = busy_reg && (!ovalid_reg || pop);
    assign finish  = produce && (!job_reg.is_frame
                                 || idx_reg == IDX_BITS'(FRAME_SIZE - 1));
    assign load    = (!busy_reg || finish) && !q_empty;
    assign q_pop   = load;
    assign empty   = !ovalid_reg;
    assign res     = res_reg;

    // Raw header sums of the incoming job
    assign ip_sum_new = IP_CONST_SUM + 20'(q_job.seq)
                        + 20'(cfg.self_ip[31:16]) + 20'(cfg.self_ip[15:0])
                        + 20'(cfg.peer_ip[31:16]) + 20'(cfg.peer_ip[15:0]);
    assign icmp_sum_new = ICMP_CONST_SUM + 20'(q_job.seq)
                          + 20'(q_job.tick[31:16]) + 20'(q_job.tick[15:0]);

    assign ip_csum   = csum_finish(ip_sum_reg);
    assign icmp_csum = csum_finish(icmp_sum_reg);

    // Select the frame byte at the current position
    always_comb
    begin
        case (idx_reg) inside
            [0:5]:   cur_byte = be_byte48(cfg.peer_mac, idx_reg);
            [6:11]:  cur_byte = be_byte48(cfg.self_mac, idx_reg - IDX_BITS'(6));
            12:      cur_byte = ETHERTYPE_IP4[15:8];
            13:      cur_byte = ETHERTYPE_IP4[7:0];
            14:      cur_byte = IP_VER_IHL;
            16:      cur_byte = IP_DGRAM_LEN[15:8];
            17:      cur_byte = IP_DGRAM_LEN[7:0];
            18, 40:  cur_byte = job_reg.seq[15:8];
            19, 41:  cur_byte = job_reg.seq[7:0];
            22:      cur_byte = IP_TTL;
            23:      cur_byte = IP_PROTO_ICMP;
            24:      cur_byte = ip_csum[15:8];
            25:      cur_byte = ip_csum[7:0];
            [26:29]: cur_byte = be_byte32(cfg.self_ip, idx_reg - IDX_BITS'(26));
            [30:33]: cur_byte = be_byte32(cfg.peer_ip, idx_reg - IDX_BITS'(30));
            34:      cur_byte = ICMP_ECHO_REQ;
            36:      cur_byte = icmp_csum[15:8];
            37:      cur_byte = icmp_csum[7:0];
            38:      cur_byte = ECHO_IDENT[15:8];
            39:      cur_byte = ECHO_IDENT[7:0];
            [42:45]: cur_byte = be_byte32(job_reg.tick, idx_reg - IDX_BITS'(42));
            [46:49]: cur_byte = be_byte32(PAYLOAD_TAG, idx_reg - IDX_BITS'(46));
            default: cur_byte = 8'h00;
        endcase
    end

    // Build the result item for this cycle
    always_comb
    begin
        item.cnt = job_reg.cnt;
        if (job_reg.is_frame)
        begin
            item.kind       = 1'b0;
            item.frame_byte = cur_byte;
            item.last       = (idx_reg == IDX_BITS'(FRAME_SIZE - 1));
            item.status     = ST_OK;
            item.rtt        = 16'd0;
        end
        else
        begin
            item.kind       = 1'b1;
            item.frame_byte = 8'h00;
            item.last       = 1'b1;
            item.status     = job_reg.status;
            item.rtt        = job_reg.rtt;
        end
    end

    // Control: job in progress, byte position, output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (finish)
                busy_reg <= 1'b0;
            else if (produce)
                idx_reg <= idx_reg + IDX_BITS'(1);

            if (produce)
                ovalid_reg <= 1'b1;
            else if (pop)
                ovalid_reg <= 1'b0;
        end
    end

    // Payload: current job, header sums, output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg      <= q_job;
            ip_sum_reg   <= ip_sum_new;
            icmp_sum_reg <= icmp_sum_new;
        end
        if (produce)
            res_reg <= item;
    end

endmodule
